// ===== rtl/psba_pkg.sv =====
// Package for the point sorter: point type, cell control struct and
// controller states. Used by psba_cell and point_sort_by_axis.
package psba_pkg;

	localparam int unsigned CoordW = 32;

	// One stored point; x in the low half when packed
	typedef struct packed {
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] x;
	} point_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;   // write the arriving point into the addressed cell
		logic sort;   // perform one compare-exchange round
		logic shift;  // move every point one cell toward the output
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Sort key selected by the axis register
	function automatic logic signed [CoordW-1:0] point_key(point_t p, logic axis);
		return axis ? p.y : p.x;
	endfunction

endpackage

// ===== rtl/point_sort_by_axis.sv =====
// Point sorter top level: collects points into a chain of cells, sorts them
// stably by the selected axis and streams them out. Uses psba_pkg, psba_cell.
// Load: one point per cycle while collecting a set.
// Sort: after the point marked last, rounds of odd-even exchange on the n points held.
// Emit: n results, one per cycle when the sink is ready, straight from cell 0.
// No input is taken in sort/emit.
// Reset (arst_n low) empties the store, clears the overflow flag and selects the x axis.
module point_sort_by_axis import psba_pkg::*; #(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] y_coord
	input  logic        s_axis_tlast,   // last_point
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y
	output logic        m_axis_tlast,   // out_last
	output logic        m_axis_tuser,   // overflowed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data        // sort_axis
);

	localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

	state_t          state_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] rnd_q;
	logic            ovf_q;
	logic            axis_q;

	cell_ctl_t       ctl;
	point_t          new_pt;
	point_t          pts     [MAX_POINTS];
	logic            gt      [MAX_POINTS];
	logic            swap_up [MAX_POINTS];
	logic            in_acc;
	logic            out_acc;
	logic            full;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign full    = (count_q == CntW'(MAX_POINTS));

	assign new_pt.x = s_axis_tdata[31:0];
	assign new_pt.y = s_axis_tdata[63:32];

	assign ctl.load  = in_acc && !full;
	assign ctl.sort  = (state_q == ST_SORT);
	assign ctl.shift = out_acc;

	// Build the chain of cells
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		point_t up_pt;
		point_t dn_pt;
		logic   hit;
		logic   swap_dn;

		if (i == MAX_POINTS - 1) begin : g_top
			assign up_pt      = pts[i];
			assign swap_up[i] = 1'b0;
		end else begin : g_mid
			assign up_pt      = pts[i+1];
			// Pair (i, i+1) is active on rounds of matching parity, inside the set
			assign swap_up[i] = (1'(i % 2) == rnd_q[0]) && (CntW'(i + 1) < count_q) && gt[i];
		end

		if (i == 0) begin : g_bot
			assign dn_pt   = pts[i];
			assign swap_dn = 1'b0;
		end else begin : g_upper
			assign dn_pt   = pts[i-1];
			assign swap_dn = swap_up[i-1];
		end

		assign hit = (count_q == CntW'(i));

		psba_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.load_hit (hit),
			.new_pt   (new_pt),
			.upper_pt (up_pt),
			.lower_pt (dn_pt),
			.swap_up  (swap_up[i]),
			.swap_dn  (swap_dn),
			.axis     (axis_q),
			.pt       (pts[i]),
			.gt_up    (gt[i])
		);
	end

	// Configuration register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			axis_q <= cfg_data[0];
		end
	end

	// Sequence load, sort and emit phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			rnd_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= ST_SORT;
							rnd_q   <= '0;
						end
					end
				end
				ST_SORT: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == CntW'(count_q - 1'b1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						count_q <= count_q - 1'b1;
						if (count_q == CntW'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Stream ports
	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = {pts[0].y, pts[0].x};
	assign m_axis_tlast  = (count_q == CntW'(1));
	assign m_axis_tuser  = ovf_q;

endmodule

// ===== rtl/psba_cell.sv =====
// One cell of the sorting chain: holds a point, compares it with its upper
// neighbor and exchanges or shifts points with its neighbors. Uses psba_pkg.
module psba_cell import psba_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      load_hit,  // this cell is the next free entry
	input  point_t    new_pt,
	input  point_t    upper_pt,  // point held by the cell above
	input  point_t    lower_pt,  // point held by the cell below
	input  logic      swap_up,   // exchange with the cell above
	input  logic      swap_dn,   // exchange with the cell below
	input  logic      axis,
	output point_t    pt,
	output logic      gt_up      // own key strictly above upper neighbor's key
);

	point_t pt_q;

	// Compare with the upper neighbor; strict so equal keys keep their order
	assign gt_up = point_key(pt_q, axis) > point_key(upper_pt, axis);
	assign pt    = pt_q;

	// Load, exchange or shift the held point
	always_ff @(posedge clk) begin
		if (ctl.load && load_hit) begin
			pt_q <= new_pt;
		end else if (ctl.sort && swap_up) begin
			pt_q <= upper_pt;
		end else if (ctl.sort && swap_dn) begin
			pt_q <= lower_pt;
		end else if (ctl.shift) begin
			pt_q <= upper_pt;
		end
	end

endmodule

// ===== rtl/psba_checker.sv =====
// Port-level checks for point_sort_by_axis, attached by the bind below.
// Depends only on the top level's ports.
module psba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result item changed");

	// Never take input while emitting
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("input ready while emitting");

	// Return to collecting right after the final item of a run
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
		else $error("no return to input after last item");

	// Keep the run going with a constant overflow flag
	a_run_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && $stable(m_axis_tuser))
		else $error("run broken or overflow flag changed");

endmodule

bind point_sort_by_axis psba_checker u_psba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
